### design/stcfa_pkg.sv
// Shared types and constants for the stacked CFA pixel finalize block.
// Used by stcfa_div, stacked_cfa_pixel_finalize and stcfa_check.
package stcfa_pkg;

    localparam int SUM_W       = 24;
    localparam int CNT_W       = 9;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_FRAMES  = 256;
    localparam int YELLOW_Q8   = 292;

    // Divider numerator width and quotient bits resolved per stage.
    localparam int NUM_W       = 36;
    localparam int DEN_W       = 9;
    localparam int DIV_STEP    = 4;
    localparam int DIV_STAGES  = NUM_W / DIV_STEP;

    // Q8 averages and signed conversion sums.
    localparam int AVG_W       = 34;
    localparam int CONV_W      = 38;
    localparam int NUM_CH      = 4;

    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {SAMPLE_BITS{1'b1}};

    typedef enum logic [1:0] {
        REG_ARRAY_MODE     = 2'd0,
        REG_FULL_THRESHOLD = 2'd1,
        REG_FRAME_COUNT    = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        CLS_REAL   = 2'd0,
        CLS_INTERP = 2'd1,
        CLS_MIX    = 2'd2
    } chan_class_t;

    typedef struct packed {
        logic        cmyg;
        chan_class_t cls0;
        chan_class_t cls1;
        chan_class_t cls2;
        chan_class_t cls3;
    } side_t;

endpackage

### design/stacked_cfa_pixel_finalize.sv
// Stacked CFA pixel finalize: per-channel averaging, CMYG conversion, clamping.
// Input, divider, mix, conversion, output registers; one word per cycle unless stalled.
// The dividers are fully pipelined (9 stages, 4 quotient bits each).
// The whole pipeline holds while the result word is stalled; no word is lost.
// Reset clears the valid bits and loads array_mode 0, full_threshold 10, frame_count 1.
// Depends on stcfa_pkg and stcfa_div.
module stacked_cfa_pixel_finalize (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [stcfa_pkg::CNT_W-1:0]        cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  logic [stcfa_pkg::SUM_W-1:0]        first_sum,
    input  logic [stcfa_pkg::SUM_W-1:0]        green_sum,
    input  logic [stcfa_pkg::SUM_W-1:0]        third_sum,
    input  logic [stcfa_pkg::SUM_W-1:0]        yellow_sum,
    input  logic [stcfa_pkg::CNT_W-1:0]        first_count,
    input  logic [stcfa_pkg::CNT_W-1:0]        green_count,
    input  logic [stcfa_pkg::CNT_W-1:0]        third_count,
    input  logic [stcfa_pkg::CNT_W-1:0]        yellow_count,
    input  logic [stcfa_pkg::SUM_W-1:0]        interp_red_sum,
    input  logic [stcfa_pkg::SUM_W-1:0]        interp_green_sum,
    input  logic [stcfa_pkg::SUM_W-1:0]        interp_blue_sum,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [stcfa_pkg::SAMPLE_BITS-1:0]  red_out,
    output logic [stcfa_pkg::SAMPLE_BITS-1:0]  green_out,
    output logic [stcfa_pkg::SAMPLE_BITS-1:0]  blue_out,
    output logic [2:0]                         full_interp_channels,
    output logic [2:0]                         partial_channels
);
    import stcfa_pkg::*;

    localparam int VPIPE = DIV_STAGES + 4;

    logic             array_mode_reg;
    logic [CNT_W-1:0] full_threshold_reg;
    logic [CNT_W-1:0] frame_count_reg;

    logic             valid_reg [VPIPE];
    logic             adv;

    // Input stage registers.
    logic [NUM_W-1:0] real_num_reg   [NUM_CH];
    logic [NUM_W-1:0] interp_num_reg [NUM_CH];
    logic [DEN_W-1:0] cnt_reg        [NUM_CH];
    logic [DEN_W-1:0] frames_reg;
    side_t            side_in_reg;

    side_t            side_next;
    logic [NUM_W-1:0] real_num_next   [NUM_CH];
    logic [NUM_W-1:0] interp_num_next [NUM_CH];
    logic [DEN_W-1:0] cnt_next        [NUM_CH];
    logic [DEN_W-1:0] frames_next;

    side_t            side_reg [DIV_STAGES];

    logic [NUM_W-1:0] real_quo   [NUM_CH];
    logic [NUM_W-1:0] interp_quo [NUM_CH];

    // Mix stage.
    logic [AVG_W-1:0] avg_reg [NUM_CH];
    logic [AVG_W-1:0] avg_next [NUM_CH];
    logic             mix_cmyg_reg;
    logic [2:0]       full_reg, full_next;
    logic [2:0]       part_reg, part_next;

    // Conversion stage.
    logic signed [CONV_W-1:0] conv_reg [3];
    logic signed [CONV_W-1:0] conv_next [3];
    logic [2:0]       full2_reg;
    logic [2:0]       part2_reg;

    // Output stage.
    logic [SAMPLE_BITS-1:0] out_reg [3];
    logic [SAMPLE_BITS-1:0] out_next [3];
    logic [2:0]       full_out_reg;
    logic [2:0]       part_out_reg;

    assign adv         = !(valid_reg[VPIPE-1] && result_stall);
    assign pixel_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_mode_reg     <= 1'b0;
            full_threshold_reg <= CNT_W'(10);
            frame_count_reg    <= CNT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ARRAY_MODE:     array_mode_reg     <= cfg_data[0];
                REG_FULL_THRESHOLD: full_threshold_reg <= cfg_data;
                REG_FRAME_COUNT:    frame_count_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VPIPE; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= pixel_valid;
            for (int i = 1; i < VPIPE; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    function automatic chan_class_t classify(input logic [CNT_W-1:0] cnt,
                                             input logic [CNT_W-1:0] thr);
        chan_class_t c;
        if (cnt == '0)
            c = CLS_INTERP;
        else if (cnt > thr)
            c = CLS_REAL;
        else
            c = CLS_MIX;
        return c;
    endfunction

    always_comb
    begin
        logic [SUM_W:0] sum_bg;
        logic [SUM_W:0] sum_br;
        logic [SUM_W:0] sum_rg;
        sum_bg = {1'b0, interp_blue_sum} + {1'b0, interp_green_sum};
        sum_br = {1'b0, interp_blue_sum} + {1'b0, interp_red_sum};
        sum_rg = {1'b0, interp_red_sum} + {1'b0, interp_green_sum};

        real_num_next[0] = NUM_W'({first_sum,  8'd0});
        real_num_next[1] = NUM_W'({green_sum,  8'd0});
        real_num_next[2] = NUM_W'({third_sum,  8'd0});
        real_num_next[3] = NUM_W'({yellow_sum, 8'd0});

        if (array_mode_reg)
        begin
            interp_num_next[0] = NUM_W'({sum_bg, 8'd0});
            interp_num_next[2] = NUM_W'({sum_br, 8'd0});
        end
        else
        begin
            interp_num_next[0] = NUM_W'({interp_red_sum, 8'd0});
            interp_num_next[2] = NUM_W'({interp_blue_sum, 8'd0});
        end
        interp_num_next[1] = NUM_W'({interp_green_sum, 8'd0});
        interp_num_next[3] = NUM_W'(sum_rg) * NUM_W'(YELLOW_Q8);

        cnt_next[0] = first_count;
        cnt_next[1] = green_count;
        cnt_next[2] = third_count;
        cnt_next[3] = yellow_count;

        if (frame_count_reg == '0)
            frames_next = DEN_W'(1);
        else if (frame_count_reg > DEN_W'(MAX_FRAMES))
            frames_next = DEN_W'(MAX_FRAMES);
        else
            frames_next = frame_count_reg;

        side_next.cmyg = array_mode_reg;
        side_next.cls0 = classify(first_count,  full_threshold_reg);
        side_next.cls1 = classify(green_count,  full_threshold_reg);
        side_next.cls2 = classify(third_count,  full_threshold_reg);
        side_next.cls3 = classify(yellow_count, full_threshold_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                real_num_reg[c]   <= real_num_next[c];
                interp_num_reg[c] <= interp_num_next[c];
                cnt_reg[c]        <= cnt_next[c];
            end
            frames_reg  <= frames_next;
            side_in_reg <= side_next;
            side_reg[0] <= side_in_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        stcfa_div u_real_div (
            .clk (clk),
            .en  (adv),
            .num (real_num_reg[c]),
            .den (cnt_reg[c]),
            .quo (real_quo[c])
        );
        stcfa_div u_interp_div (
            .clk (clk),
            .en  (adv),
            .num (interp_num_reg[c]),
            .den (frames_reg),
            .quo (interp_quo[c])
        );
    end

    // Pick each channel's Q8 average; count fully and partly interpolated channels.
    always_comb
    begin
        chan_class_t cls [NUM_CH];
        logic [AVG_W:0] mix;
        logic [2:0]     nf;
        logic [2:0]     np;
        side_t          sd;
        sd     = side_reg[DIV_STAGES-1];
        cls[0] = sd.cls0;
        cls[1] = sd.cls1;
        cls[2] = sd.cls2;
        cls[3] = sd.cls3;
        nf     = '0;
        np     = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            mix = {1'b0, real_quo[c][AVG_W-1:0]} + {1'b0, interp_quo[c][AVG_W-1:0]};
            case (cls[c])
                CLS_REAL:   avg_next[c] = real_quo[c][AVG_W-1:0];
                CLS_INTERP: avg_next[c] = interp_quo[c][AVG_W-1:0];
                CLS_MIX:    avg_next[c] = mix[AVG_W:1];
                default:    avg_next[c] = '0;
            endcase
            // Yellow only counts in the complementary mosaic.
            if (c < NUM_CH - 1 || sd.cmyg)
            begin
                if (cls[c] == CLS_INTERP)
                    nf = nf + 3'd1;
                if (cls[c] == CLS_MIX)
                    np = np + 3'd1;
            end
        end
        full_next = nf;
        part_next = np;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                avg_reg[c] <= avg_next[c];
            end
            mix_cmyg_reg <= side_reg[DIV_STAGES-1].cmyg;
            full_reg     <= full_next;
            part_reg     <= part_next;
        end
    end

    // The RGB values are scaled by four so both modes share the divide by 1024.
    always_comb
    begin
        logic signed [CONV_W-1:0] cc;
        logic signed [CONV_W-1:0] mm;
        logic signed [CONV_W-1:0] yy;
        logic signed [CONV_W-1:0] gg;
        cc = signed'(CONV_W'(avg_reg[0]));
        gg = signed'(CONV_W'(avg_reg[1]));
        mm = signed'(CONV_W'(avg_reg[2]));
        yy = signed'(CONV_W'(avg_reg[3]));
        if (mix_cmyg_reg)
        begin
            conv_next[0] = yy + mm + (mm <<< 1) + (gg <<< 1) - cc - (cc <<< 1);
            conv_next[1] = cc + yy - mm + (gg <<< 1);
            conv_next[2] = cc + mm + (mm <<< 1) + (gg <<< 1) - yy - (yy <<< 1);
        end
        else
        begin
            conv_next[0] = cc <<< 2;
            conv_next[1] = gg <<< 2;
            conv_next[2] = mm <<< 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                conv_reg[i] <= conv_next[i];
            end
            full2_reg <= full_reg;
            part2_reg <= part_reg;
        end
    end

    always_comb
    begin
        logic [CONV_W-11:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = conv_reg[i][CONV_W-1:10];
            if (conv_reg[i][CONV_W-1])
                out_next[i] = '0;
            else if (q > (CONV_W-10)'(OUT_MAX))
                out_next[i] = OUT_MAX;
            else
                out_next[i] = q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= out_next[i];
            end
            full_out_reg <= full2_reg;
            part_out_reg <= part2_reg;
        end
    end

    assign result_valid         = valid_reg[VPIPE-1];
    assign red_out              = out_reg[0];
    assign green_out            = out_reg[1];
    assign blue_out             = out_reg[2];
    assign full_interp_channels = full_out_reg;
    assign partial_channels     = part_out_reg;

endmodule

### design/stcfa_div.sv
// Pipelined restoring divider, DIV_STEP quotient bits per register stage.
// Depends on stcfa_pkg for widths and stage count.
module stcfa_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [stcfa_pkg::NUM_W-1:0] num,
    input  logic [stcfa_pkg::DEN_W-1:0] den,
    output logic [stcfa_pkg::NUM_W-1:0] quo
);
    import stcfa_pkg::*;

    logic [NUM_W-1:0] num_reg [DIV_STAGES];
    logic [NUM_W-1:0] quo_reg [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];

    logic [NUM_W-1:0] num_next [DIV_STAGES];
    logic [NUM_W-1:0] quo_next [DIV_STAGES];
    logic [DEN_W-1:0] rem_next [DIV_STAGES];
    logic [DEN_W-1:0] den_src  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_comb
            begin
                logic [NUM_W-1:0] n;
                logic [NUM_W-1:0] q;
                logic [DEN_W-1:0] r;
                logic [DEN_W:0]   t;
                n = num;
                q = '0;
                r = '0;
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    t = {r, n[NUM_W-1]};
                    n = {n[NUM_W-2:0], 1'b0};
                    if (t >= {1'b0, den})
                    begin
                        t = t - {1'b0, den};
                        q = {q[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[NUM_W-2:0], 1'b0};
                    end
                    r = t[DEN_W-1:0];
                end
                num_next[s] = n;
                quo_next[s] = q;
                rem_next[s] = r;
                den_src[s]  = den;
            end
        end
        else begin : g_rest
            always_comb
            begin
                logic [NUM_W-1:0] n;
                logic [NUM_W-1:0] q;
                logic [DEN_W-1:0] r;
                logic [DEN_W:0]   t;
                n = num_reg[s-1];
                q = quo_reg[s-1];
                r = rem_reg[s-1];
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    t = {r, n[NUM_W-1]};
                    n = {n[NUM_W-2:0], 1'b0};
                    if (t >= {1'b0, den_reg[s-1]})
                    begin
                        t = t - {1'b0, den_reg[s-1]};
                        q = {q[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[NUM_W-2:0], 1'b0};
                    end
                    r = t[DEN_W-1:0];
                end
                num_next[s] = n;
                quo_next[s] = q;
                rem_next[s] = r;
                den_src[s]  = den_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s] <= num_next[s];
                quo_reg[s] <= quo_next[s];
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_src[s];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

### design/stcfa_check.sv
// Port-level checks for stacked_cfa_pixel_finalize, attached with a bind.
// Depends on stcfa_pkg for port widths.
module stcfa_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              pixel_stall,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic [stcfa_pkg::SAMPLE_BITS-1:0] red_out,
    input logic [2:0]                        full_interp_channels,
    input logic [2:0]                        partial_channels
);
    import stcfa_pkg::*;

    // The input side only waits on a stalled result word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (result_valid && result_stall))
        else $error("input stalled without a stalled result word");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !pixel_stall)
        else $error("input stalled while output empty");

    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, full_interp_channels} + {1'b0, partial_channels}) <= 4'd4)
        else $error("channel counts exceed four");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result word dropped under stall");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(red_out))
        else $error("result word changed under stall");

endmodule

bind stacked_cfa_pixel_finalize stcfa_check u_stcfa_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .pixel_stall          (pixel_stall),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .red_out              (red_out),
    .full_interp_channels (full_interp_channels),
    .partial_channels     (partial_channels)
);

### tb/testbench.sv
// Testbench for stacked_cfa_pixel_finalize: drives pixel words, predicts each result word.
// Depends on stcfa_pkg and the design files of the block.
`timescale 1ns / 100ps

module testbench;
    import stcfa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [23:0] s1, sg, s3, sy;
        logic [8:0]  c1, cg, c3, cy;
        logic [23:0] ir, ig, ib;
    } pixel_t;

    typedef struct {
        logic [15:0] r, g, b;
        logic [2:0]  full, part;
    } rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [8:0] cfg_data = 9'd0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    logic [23:0] first_sum = '0, green_sum = '0, third_sum = '0, yellow_sum = '0;
    logic [8:0] first_count = '0, green_count = '0, third_count = '0, yellow_count = '0;
    logic [23:0] interp_red_sum = '0, interp_green_sum = '0, interp_blue_sum = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [15:0] red_out, green_out, blue_out;
    logic [2:0] full_interp_channels, partial_channels;

    logic       mode_q = 1'b0;
    logic [8:0] thresh_q = 9'd10;
    logic [8:0] frames_q = 9'd1;

    rgb_t pending_pixels[$];
    int   errors = 0;
    int   cycles = 0;
    bit   idle_off = 1'b0;

    stacked_cfa_pixel_finalize i_dut (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic longint chan_avg(longint sum, longint cnt, longint inum,
                                        ref int full, ref int part);
        longint f;
        longint interp;
        f = longint'(frames_q);
        if (f == 0) f = 1;
        if (f > longint'(MAX_FRAMES)) f = longint'(MAX_FRAMES);
        interp = inum / f;
        if (cnt > longint'(thresh_q) && cnt != 0) return (sum << 8) / cnt;
        if (cnt == 0)
        begin
            full++;
            return interp;
        end
        part++;
        return (((sum << 8) / cnt) + interp) >>> 1;
    endfunction

    function automatic logic [15:0] clamp_avg(longint v);
        longint r;
        r = v >>> 8;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [15:0] clamp_cmyg(longint n);
        longint r;
        if (n < 0) return 16'd0;
        r = n / 1024;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic rgb_t finalize_pixel(pixel_t p);
        rgb_t o;
        int full;
        int part;
        longint cc, mm, yy, gg;
        full = 0;
        part = 0;
        if (!mode_q)
        begin
            o.r = clamp_avg(chan_avg(longint'(p.s1), longint'(p.c1),
                                     longint'(p.ir) << 8, full, part));
            o.g = clamp_avg(chan_avg(longint'(p.sg), longint'(p.cg),
                                     longint'(p.ig) << 8, full, part));
            o.b = clamp_avg(chan_avg(longint'(p.s3), longint'(p.c3),
                                     longint'(p.ib) << 8, full, part));
        end
        else
        begin
            cc = chan_avg(longint'(p.s1), longint'(p.c1),
                          (longint'(p.ib) + longint'(p.ig)) << 8, full, part);
            mm = chan_avg(longint'(p.s3), longint'(p.c3),
                          (longint'(p.ib) + longint'(p.ir)) << 8, full, part);
            yy = chan_avg(longint'(p.sy), longint'(p.cy),
                          longint'(YELLOW_Q8) * (longint'(p.ir) + longint'(p.ig)),
                          full, part);
            gg = chan_avg(longint'(p.sg), longint'(p.cg),
                          longint'(p.ig) << 8, full, part);
            o.r = clamp_cmyg(yy + 3 * mm + 2 * gg - 3 * cc);
            o.g = clamp_cmyg(cc + yy - mm + 2 * gg);
            o.b = clamp_cmyg(cc + 3 * mm + 2 * gg - 3 * yy);
        end
        o.full = full[2:0];
        o.part = part[2:0];
        return o;
    endfunction

    // Receiver side: random stall and the result check.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        if (rst_n)
        begin
            result_stall <= !idle_off && ($urandom_range(99) < 13);
            if (result_valid && !result_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result word r=%0d", $time, red_out);
                    errors <= errors + 1;
                end
                else
                begin
                    rgb_t e;
                    e = pending_pixels.pop_front();
                    if (e.r !== red_out || e.g !== green_out || e.b !== blue_out ||
                        e.full !== full_interp_channels || e.part !== partial_channels)
                    begin
                        $display("%0t: expected %0d %0d %0d f%0d p%0d, actual %0d %0d %0d f%0d p%0d",
                                 $time, e.r, e.g, e.b, e.full, e.part, red_out, green_out,
                                 blue_out, full_interp_channels, partial_channels);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    task automatic send_pixel(pixel_t p);
        while (!idle_off && $urandom_range(99) < 13)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        first_sum <= p.s1; green_sum <= p.sg; third_sum <= p.s3; yellow_sum <= p.sy;
        first_count <= p.c1; green_count <= p.cg; third_count <= p.c3;
        yellow_count <= p.cy;
        interp_red_sum <= p.ir; interp_green_sum <= p.ig; interp_blue_sum <= p.ib;
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
        pending_pixels.push_back(finalize_pixel(p));
    endtask

    task automatic drain;
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [8:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ARRAY_MODE:     mode_q = val[0];
            REG_FULL_THRESHOLD: thresh_q = val;
            REG_FRAME_COUNT:    frames_q = val;
            default:            ;
        endcase
    endtask

    function automatic logic [8:0] rand_count();
        case ($urandom_range(5))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'($urandom_range(511));
            default: return 9'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [23:0] rand_sum(logic [8:0] cnt);
        case ($urandom_range(3))
            0: return 24'($urandom());
            1: return 24'hFFFFFF;
            default: return 24'($urandom_range(32'(cnt) * 32'd65535));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.c1 = rand_count(); p.cg = rand_count(); p.c3 = rand_count(); p.cy = rand_count();
        p.s1 = rand_sum(p.c1); p.sg = rand_sum(p.cg); p.s3 = rand_sum(p.c3);
        p.sy = rand_sum(p.cy);
        p.ir = rand_sum(frames_q); p.ig = rand_sum(frames_q); p.ib = rand_sum(frames_q);
        return p;
    endfunction

    task automatic test_corners;
        pixel_t p;
        for (int i = 0; i < 12; i++)
        begin
            p.c1 = (i & 1) ? 9'd0 : 9'd511;
            p.cg = (i & 2) ? 9'd1 : 9'd256;
            p.c3 = (i % 3 == 0) ? 9'd0 : 9'd5;
            p.cy = (i & 4) ? 9'd0 : 9'd11;
            p.s1 = (i & 1) ? 24'd0 : 24'hFFFFFF;
            p.sg = (i & 2) ? 24'hFFFFFF : 24'd0;
            p.s3 = (i & 4) ? 24'd1 : 24'hFFFFFF;
            p.sy = (i & 8) ? 24'hFFFFFF : 24'd0;
            p.ir = (i & 1) ? 24'hFFFFFF : 24'd0;
            p.ig = (i & 2) ? 24'd0 : 24'hFFFFFF;
            p.ib = (i & 8) ? 24'hFFFFFF : 24'd300;
            send_pixel(p);
        end
    endtask

    task automatic test_rgb_mode;
        write_reg(REG_ARRAY_MODE, 9'd0);
        write_reg(REG_FULL_THRESHOLD, 9'd0);
        write_reg(REG_FRAME_COUNT, 9'd0);
        test_corners();
        drain();
        write_reg(REG_FULL_THRESHOLD, 9'd511);
        write_reg(REG_FRAME_COUNT, 9'd511);
        repeat (100) send_pixel(rand_pixel());
        drain();
    endtask

    task automatic test_cmyg_mode;
        write_reg(REG_ARRAY_MODE, 9'd1);
        write_reg(REG_FULL_THRESHOLD, 9'd10);
        write_reg(REG_FRAME_COUNT, 9'd1);
        test_corners();
        repeat (100) send_pixel(rand_pixel());
        drain();
        write_reg(REG_FULL_THRESHOLD, 9'd256);
        write_reg(REG_FRAME_COUNT, 9'd256);
        repeat (100) send_pixel(rand_pixel());
        drain();
    endtask

    task automatic test_random_settings;
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_ARRAY_MODE, 9'($urandom()));
            write_reg(REG_FULL_THRESHOLD, 9'($urandom_range(511)));
            write_reg(REG_FRAME_COUNT, 9'($urandom_range(511)));
            // Sender waits mid-phase for the pipeline to empty.
            repeat (20) send_pixel(rand_pixel());
            drain();
            idle_off = (k == 2);
            repeat (20) send_pixel(rand_pixel());
            drain();
            idle_off = 1'b0;
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        test_rgb_mode();
        test_cmyg_mode();
        test_random_settings();
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
